/* sv/svs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_pkg
// Shared types and constants for the sorted value store.
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int KIND_W     = 3;
  localparam int FIELD_W    = 32;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int LEN_W      = 5;
  localparam int ERR_W      = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_POP    = 3'd1,
    KIND_READ   = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_KEEP   = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_RANGE = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    RD_HEAD  = 2'd0,
    RD_TOP   = 2'd1,
    RD_INDEX = 2'd2,
    RD_BELOW = 2'd3
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT = 1'b0,
    WR_VALUE = 1'b1
  } wr_sel_t;

  typedef enum logic [2:0] {
    OCC_HOLD = 3'd0,
    OCC_INC  = 3'd1,
    OCC_DEC  = 3'd2,
    OCC_CLR  = 3'd3,
    OCC_SUB  = 3'd4,
    OCC_SET  = 3'd5
  } occ_op_t;

  typedef enum logic [1:0] {
    HEAD_HOLD = 2'd0,
    HEAD_INC  = 2'd1,
    HEAD_ADD  = 2'd2
  } head_op_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     p_dec;
    occ_op_t  occ_op;
    head_op_t head_op;
    logic     err_set;
    err_t     err_code;
    logic     rv_cap;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  empty;
    logic  idx_oob;
    logic  cnt_ge_occ;
    logic  shift_on;
    logic  p_one;
  } dp_stat_t;

endpackage

/* sv/svs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_datapath
// Circular value memory with head pointer, occupancy, item and result registers.
// ----------------------------------------------------------------------------
module svs_datapath #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  svs_pkg::dp_cmd_t                cmd,
  output svs_pkg::dp_stat_t               stat,
  input  logic [svs_pkg::KIND_W-1:0]      in_kind,
  input  logic [svs_pkg::FIELD_W-1:0]     in_value,
  input  logic [svs_pkg::IDX_W-1:0]       in_index,
  input  logic [svs_pkg::CNT_W-1:0]       in_count,
  output logic [svs_pkg::OUT_DATA_W-1:0]  out_data
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int CW     = (OCC_W > svs_pkg::CNT_W) ? OCC_W : svs_pkg::CNT_W;

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= SUM_W'(CAPACITY)) s = s - SUM_W'(CAPACITY);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [svs_pkg::FIELD_W-1:0] to_field(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH+svs_pkg::FIELD_W-1:0] x;
    x = {{svs_pkg::FIELD_W{v[VALUE_WIDTH-1]}}, v};
    return x[svs_pkg::FIELD_W-1:0];
  endfunction

  logic [VALUE_WIDTH-1:0]           mem_r [CAPACITY];
  logic signed [VALUE_WIDTH-1:0]    rdata_r;
  logic signed [VALUE_WIDTH-1:0]    val_r;
  svs_pkg::kind_t                   kind_r;
  logic [svs_pkg::IDX_W-1:0]        idx_r;
  logic [svs_pkg::CNT_W-1:0]        cnt_r;
  logic [OCC_W-1:0]                 occ_r, occ_nxt;
  logic [OCC_W-1:0]                 p_r;
  logic [ADDR_W-1:0]                head_r, head_nxt;
  svs_pkg::err_t                    err_r;
  logic [svs_pkg::FIELD_W-1:0]      rv_r;
  logic [svs_pkg::OUT_DATA_W-1:0]   out_data_r;

  logic [2*svs_pkg::FIELD_W-1:0]    val_ext;
  logic [CW-1:0]                    occ_c, idx_c, cnt_c;
  logic [OCC_W-1:0]                 occ_m1, p_m2;
  logic [ADDR_W-1:0]                rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0]           wr_data;
  logic                             empty;
  logic [svs_pkg::FIELD_W-1:0]      head_val;

  assign val_ext = {{svs_pkg::FIELD_W{in_value[svs_pkg::FIELD_W-1]}}, in_value};
  assign occ_c   = CW'(occ_r);
  assign idx_c   = CW'(idx_r);
  assign cnt_c   = CW'(cnt_r);
  assign occ_m1  = occ_r - OCC_W'(1);
  assign p_m2    = p_r - OCC_W'(2);
  assign empty   = (occ_r == '0);

  assign stat.kind       = kind_r;
  assign stat.full       = (occ_r == OCC_W'(CAPACITY));
  assign stat.empty      = empty;
  assign stat.idx_oob    = (idx_c >= occ_c);
  assign stat.cnt_ge_occ = (cnt_c >= occ_c);
  assign stat.shift_on   = (rdata_r >= val_r);
  assign stat.p_one      = (p_r == OCC_W'(1));

  always_comb begin
    case (cmd.rd_sel)
      svs_pkg::RD_HEAD:  rd_addr = head_r;
      svs_pkg::RD_TOP:   rd_addr = wrap_add(head_r, occ_m1[ADDR_W-1:0]);
      svs_pkg::RD_INDEX: rd_addr = wrap_add(head_r, idx_c[ADDR_W-1:0]);
      svs_pkg::RD_BELOW: rd_addr = wrap_add(head_r, p_m2[ADDR_W-1:0]);
      default:           rd_addr = head_r;
    endcase
  end

  assign wr_addr = wrap_add(head_r, p_r[ADDR_W-1:0]);
  assign wr_data = (cmd.wr_sel == svs_pkg::WR_VALUE) ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem_r[wr_addr] <= wr_data;
    if (cmd.rd_en) rdata_r <= mem_r[rd_addr];
  end

  always_comb begin
    case (cmd.occ_op)
      svs_pkg::OCC_INC: occ_nxt = occ_r + OCC_W'(1);
      svs_pkg::OCC_DEC: occ_nxt = occ_m1;
      svs_pkg::OCC_CLR: occ_nxt = '0;
      svs_pkg::OCC_SUB: occ_nxt = occ_r - cnt_c[OCC_W-1:0];
      svs_pkg::OCC_SET: occ_nxt = cnt_c[OCC_W-1:0];
      default:          occ_nxt = occ_r;
    endcase
    case (cmd.head_op)
      svs_pkg::HEAD_INC: head_nxt = wrap_add(head_r, ADDR_W'(1));
      svs_pkg::HEAD_ADD: head_nxt = wrap_add(head_r, cnt_c[ADDR_W-1:0]);
      default:           head_nxt = head_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      head_r <= '0;
    end else begin
      occ_r  <= occ_nxt;
      head_r <= head_nxt;
    end
  end

  assign head_val = empty ? '0 : to_field(rdata_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= svs_pkg::kind_t'(in_kind);
      val_r  <= val_ext[VALUE_WIDTH-1:0];
      idx_r  <= in_index;
      cnt_r  <= in_count;
      p_r    <= occ_r;
      err_r  <= svs_pkg::ERR_OK;
      rv_r   <= '0;
    end else begin
      if (cmd.p_dec)   p_r   <= p_r - OCC_W'(1);
      if (cmd.err_set) err_r <= cmd.err_code;
      if (cmd.rv_cap)  rv_r  <= to_field(rdata_r);
    end
    if (cmd.out_load)
      out_data_r <= {err_r, empty, occ_c[svs_pkg::LEN_W-1:0], head_val, rv_r};
  end

  assign out_data = out_data_r;

endmodule

/* sv/svs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_ctrl
// Operation sequencer and output handshake for the sorted value store.
// ----------------------------------------------------------------------------
module svs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  svs_pkg::dp_stat_t  stat,
  output svs_pkg::dp_cmd_t   cmd
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_EXEC     = 7'b0000010,
    ST_RD_WAIT  = 7'b0000100,
    ST_INS_CMP  = 7'b0001000,
    ST_INS_PUT  = 7'b0010000,
    ST_HEAD_RD  = 7'b0100000,
    ST_HEAD_CAP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_HEAD_RD;
        case (stat.kind)
          svs_pkg::KIND_INSERT: begin
            if (stat.full) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = svs_pkg::ERR_FULL;
            end else if (stat.empty) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = svs_pkg::WR_VALUE;
              cmd.occ_op = svs_pkg::OCC_INC;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = svs_pkg::RD_TOP;
              state_nxt  = ST_INS_CMP;
            end
          end
          svs_pkg::KIND_POP: begin
            if (stat.empty) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = svs_pkg::ERR_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = svs_pkg::RD_HEAD;
              state_nxt  = ST_RD_WAIT;
            end
          end
          svs_pkg::KIND_READ: begin
            if (stat.idx_oob) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = svs_pkg::ERR_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = svs_pkg::RD_INDEX;
              state_nxt  = ST_RD_WAIT;
            end
          end
          svs_pkg::KIND_DROP: begin
            if (stat.cnt_ge_occ) begin
              cmd.occ_op = svs_pkg::OCC_CLR;
            end else begin
              cmd.occ_op  = svs_pkg::OCC_SUB;
              cmd.head_op = svs_pkg::HEAD_ADD;
            end
          end
          svs_pkg::KIND_KEEP: begin
            if (!stat.cnt_ge_occ) cmd.occ_op = svs_pkg::OCC_SET;
          end
          svs_pkg::KIND_CLEAR: cmd.occ_op = svs_pkg::OCC_CLR;
          default: ;
        endcase
      end
      ST_RD_WAIT: begin
        cmd.rv_cap = 1'b1;
        if (stat.kind == svs_pkg::KIND_POP) begin
          cmd.occ_op  = svs_pkg::OCC_DEC;
          cmd.head_op = svs_pkg::HEAD_INC;
        end
        state_nxt = ST_HEAD_RD;
      end
      ST_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.shift_on) begin
          cmd.wr_sel = svs_pkg::WR_SHIFT;
          cmd.p_dec  = 1'b1;
          if (stat.p_one) begin
            state_nxt = ST_INS_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = svs_pkg::RD_BELOW;
          end
        end else begin
          cmd.wr_sel = svs_pkg::WR_VALUE;
          cmd.occ_op = svs_pkg::OCC_INC;
          state_nxt  = ST_HEAD_RD;
        end
      end
      ST_INS_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = svs_pkg::WR_VALUE;
        cmd.occ_op = svs_pkg::OCC_INC;
        state_nxt  = ST_HEAD_RD;
      end
      ST_HEAD_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = svs_pkg::RD_HEAD;
        state_nxt  = ST_HEAD_CAP;
      end
      ST_HEAD_CAP: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/sorted_value_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_value_store
// Bounded ascending store of signed values used as a priority queue.
// Sequence after acceptance: execute; then a read-wait state for pop and read,
// or, for an insert into a nonempty store, one compare state per entry read
// and a put state when the value goes to the head; then head read and capture.
// One item in flight; a new item is taken only after the last result has
// been loaded into the output register, where results wait.
// Reset (sync, active low) empties the store; stored values are not cleared.
// ----------------------------------------------------------------------------
module sorted_value_store #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [svs_pkg::KIND_W-1:0]      in_tuser,   // kind
  input  logic [svs_pkg::IN_DATA_W-1:0]   in_tdata,   // value, index, count
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [svs_pkg::OUT_DATA_W-1:0]  out_tdata   // read_value, head_value,
                                                      // length, is_empty, error
);

  svs_pkg::dp_cmd_t  cmd;
  svs_pkg::dp_stat_t stat;

  svs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  svs_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_kind  (in_tuser),
    .in_value (in_tdata[31:0]),
    .in_index (in_tdata[35:32]),
    .in_count (in_tdata[40:36]),
    .out_data (out_tdata)
  );

endmodule

/* sv/svs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_checker
// Port-level checks for the sorted value store, bound to the top level.
// ----------------------------------------------------------------------------
module svs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [svs_pkg::KIND_W-1:0]      in_tuser,
  input logic [svs_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [svs_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic [svs_pkg::ERR_W-1:0] out_err;
  assign out_err = out_tdata[71:70];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[69] |-> out_tdata[68:64] == '0 && out_tdata[63:32] == '0)
    else $error("empty store reports nonzero length or head");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_err == svs_pkg::ERR_EMPTY |-> out_tdata[69] && out_tdata[31:0] == '0)
    else $error("pop error on a nonempty store");

  a_no_tx_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind sorted_value_store svs_checker u_svs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted value store through directed and random transactions.
// Every accepted operation updates a behavioral copy of the ascending
// store. The copy predicts each result, and every returned result is checked
// field by field against the oldest pending prediction. Both stream sides
// idle at random, and once the result side holds off long enough to stall
// the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1525;
  localparam int CALM_ITEMS   = 200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  // encodings the block treats as no-ops
  localparam logic [svs_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [svs_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

  typedef struct packed {
    svs_pkg::err_t             error;
    logic                      is_empty;
    logic [svs_pkg::LEN_W-1:0] length;
    logic signed [31:0]        head_value;
    logic signed [31:0]        read_value;
  } reply_t;

  class store_tracker;
    logic signed [31:0] slots[DEPTH];
    int                 fill = 0;
    int                 errors = 0;
    reply_t             pending[$];

    function void note_request(logic [svs_pkg::KIND_W-1:0] kind,
                               logic signed [31:0] value,
                               logic [svs_pkg::IDX_W-1:0] idx,
                               logic [svs_pkg::CNT_W-1:0] cnt);
      reply_t r;
      int     pos;
      r.read_value = '0;
      r.error      = svs_pkg::ERR_OK;
      case (kind)
        svs_pkg::KIND_INSERT: begin
          if (fill >= DEPTH) begin
            r.error = svs_pkg::ERR_FULL;
          end else begin
            pos = 0;
            while (pos < fill && value > slots[pos]) pos++;
            for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = value;
            fill++;
          end
        end
        svs_pkg::KIND_POP: begin
          if (fill == 0) begin
            r.error = svs_pkg::ERR_EMPTY;
          end else begin
            r.read_value = slots[0];
            for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
            fill--;
          end
        end
        svs_pkg::KIND_READ: begin
          if (idx >= fill) r.error = svs_pkg::ERR_RANGE;
          else r.read_value = slots[idx];
        end
        svs_pkg::KIND_DROP: begin
          if (cnt >= fill) begin
            fill = 0;
          end else begin
            for (int i = cnt; i < fill; i++) slots[i-cnt] = slots[i];
            fill -= cnt;
          end
        end
        svs_pkg::KIND_KEEP: begin
          if (cnt < fill) fill = cnt;
        end
        svs_pkg::KIND_CLEAR: fill = 0;
        default: ;
      endcase
      r.head_value = (fill != 0) ? slots[0] : '0;
      r.length     = fill[svs_pkg::LEN_W-1:0];
      r.is_empty   = (fill == 0);
      pending.push_back(r);
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_reply(logic [svs_pkg::OUT_DATA_W-1:0] tdata);
      reply_t got;
      reply_t want;
      got = reply_t'(tdata);
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, tdata);
      end else begin
        want = pending.pop_front();
        report_field("read_value", want.read_value, got.read_value);
        report_field("head_value", want.head_value, got.head_value);
        report_field("length", 32'(want.length), 32'(got.length));
        report_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        report_field("error", 32'(want.error), 32'(got.error));
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [svs_pkg::KIND_W-1:0]     in_tuser = '0;
  logic [svs_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [svs_pkg::OUT_DATA_W-1:0] out_tdata;

  store_tracker board = new();
  int           sent = 0;
  int           cycles = 0;
  bit           calm = 1'b0;
  bit           hold_armed = 1'b0;

  sorted_value_store i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_reply(out_tdata);
  end

  // result side: random stalls, one long hold-off, none near the end
  initial begin
    while (1) begin
      if (hold_armed) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_armed = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [svs_pkg::KIND_W-1:0] kind, logic signed [31:0] value,
                           logic [svs_pkg::IDX_W-1:0] idx,
                           logic [svs_pkg::CNT_W-1:0] cnt);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, cnt, idx, value};
    do @(posedge clk); while (!in_tready);
    board.note_request(kind, value, idx, cnt);
    sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 16)) - 32'sd8;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    int                          r;
    int                          insert_share;
    logic [svs_pkg::KIND_W-1:0]  kind;
    logic [svs_pkg::IDX_W-1:0]   idx;
    logic [svs_pkg::CNT_W-1:0]   cnt;
    insert_share = (board.fill < 12) ? 55 : 35;
    r = $urandom_range(0, 99);
    if (r < insert_share) kind = svs_pkg::KIND_INSERT;
    else if (r < insert_share + 15) kind = svs_pkg::KIND_POP;
    else if (r < insert_share + 35) kind = svs_pkg::KIND_READ;
    else if (r < insert_share + 41) kind = svs_pkg::KIND_DROP;
    else if (r < insert_share + 47) kind = svs_pkg::KIND_KEEP;
    else if (r < insert_share + 50) kind = svs_pkg::KIND_CLEAR;
    else if (r < insert_share + 52) kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    else kind = svs_pkg::KIND_READ;
    if ($urandom_range(0, 3) == 0 || board.fill == 0)
      idx = svs_pkg::IDX_W'($urandom_range(0, 15));
    else
      idx = svs_pkg::IDX_W'($urandom_range(0, board.fill - 1));
    cnt = ($urandom_range(0, 3) == 0) ? svs_pkg::CNT_W'($urandom_range(0, 16))
                                      : svs_pkg::CNT_W'($urandom_range(0, 3));
    send_item(kind, pick_value(), idx, cnt);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_item(svs_pkg::KIND_CLEAR, '0, '0, '0);
    send_item(svs_pkg::KIND_POP, '0, '0, '0);
    send_item(svs_pkg::KIND_READ, '0, '0, '0);
    send_item(KIND_SPARE_A, 32'h1234_5678, 4'd15, 5'd16);
    send_item(KIND_SPARE_B, '0, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h7fff_ffff, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h8000_0000, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h0000_0000, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'hffff_ffff, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h0000_0000, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h0000_0001, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h8000_0000, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h7fff_ffff, '0, '0);
    repeat (9) send_item(svs_pkg::KIND_INSERT, $urandom, '0, '0);
    send_item(svs_pkg::KIND_INSERT, 32'h5555_aaaa, '0, '0);
    send_item(svs_pkg::KIND_READ, '0, 4'd15, '0);
    send_item(svs_pkg::KIND_POP, '0, '0, '0);
    send_item(svs_pkg::KIND_KEEP, '0, '0, 5'd16);
    send_item(svs_pkg::KIND_DROP, '0, '0, 5'd3);
    send_item(svs_pkg::KIND_DROP, '0, '0, 5'd16);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_armed = 1'b1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random();
    end
    in_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
